// ----- rtl/linear_adrc_observer_controller_core_defines.svh -----
// Assertion macros shared by the checker of the ADRC observer and controller core.
`ifndef LINEAR_ADRC_OBSERVER_CONTROLLER_CORE_DEFINES_SVH
`define LINEAR_ADRC_OBSERVER_CONTROLLER_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define LADRC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ladrc assertion failed");

// The consequent must hold in the same cycle as the antecedent, reset included.
`define LADRC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("ladrc assertion failed");

`endif

// ----- rtl/ladrc_pkg.sv -----
// Types, register indexes and saturation helpers of the ADRC observer and controller core.
package ladrc_pkg;

   typedef struct packed {
      logic               action;
      logic signed [15:0] applied_drive;
      logic signed [15:0] measured;
      logic signed [15:0] setpoint;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic signed [31:0] est_position;
      logic signed [31:0] est_rate;
      logic signed [31:0] est_disturbance;
      logic               saturated;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic start;
      logic long_op;
   } smul_ctrl_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               hit;
   } clip32_type;

   typedef struct packed {
      logic signed [15:0] value;
      logic               hit;
   } clip16_type;

   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_OBS_ROW0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OBS_ROW1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBS_ROW2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_IN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_IN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_PLANT = 3'd7;

   localparam logic signed [65:0] MAX32 = 66'sd2147483647;
   localparam logic signed [65:0] MIN32 = -66'sd2147483648;
   localparam logic signed [65:0] MAX16 = 66'sd32767;
   localparam logic signed [65:0] MIN16 = -66'sd32768;

   function automatic clip32_type clip32(input logic signed [65:0] v);
      clip32_type r;
      if (v > MAX32) begin
         r.value = 32'sh7FFF_FFFF;
         r.hit   = 1'b1;
      end else if (v < MIN32) begin
         r.value = 32'sh8000_0000;
         r.hit   = 1'b1;
      end else begin
         r.value = v[31:0];
         r.hit   = 1'b0;
      end
      return r;
   endfunction

   function automatic clip16_type clip16(input logic signed [65:0] v);
      clip16_type r;
      if (v > MAX16) begin
         r.value = 16'sh7FFF;
         r.hit   = 1'b1;
      end else if (v < MIN16) begin
         r.value = 16'sh8000;
         r.hit   = 1'b1;
      end else begin
         r.value = v[15:0];
         r.hit   = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- rtl/linear_adrc_observer_controller_core.sv -----
// Top level of the second-order linear ADRC observer and controller core.
//
// Usage: software loads the discretised observer matrix, the drive and measurement
// gains (packed Q2.14) and the controller gains (Q16.16) through the csr_ write port
// while the block is idle. Each req_ item carries an action, the drive applied last
// period, the measurement and the setpoint; each one yields exactly one rsp_ item with
// the new drive, the three estimates and a saturation flag.
// One item is worked on at a time. A control step runs fifteen 16-bit multiplies
// and three 32-bit multiplies on one bit-serial multiplier, each issued from the
// issue state and collected in the wait state. The last multiply fills the result
// register, and the finish state moves it to the output register once that is
// free; only then is the block idle and can take the next item. The serial
// multiplier sets the pace. A clear item goes straight to the finish state with a
// zeroed result.
// A finished result waits in the output register; the next item may be accepted while it
// waits, and a later result is held back until the receiver takes the earlier one.
// Reset clears the configuration registers, the estimates and the output valid, and returns the sequencer to idle.
module linear_adrc_observer_controller_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ladrc_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ladrc_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_we,
   input  logic [ladrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ladrc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [47:0]        obs_row0_ff, obs_row1_ff, obs_row2_ff;
   logic [47:0]        bu_ff, by_ff;
   logic signed [31:0] gain_p_ff, gain_d_ff, inv_ff;

   // Sequencer and datapath state.
   ladrc_pkg::state_type state_ff, state_in;
   logic signed [31:0] est_ff [3];
   logic signed [31:0] nx_ff [3];
   logic signed [55:0] acc_ff;
   logic signed [49:0] p_ff;
   logic signed [31:0] v_ff;
   logic signed [15:0] u_ff, y_ff, r_ff;
   logic [1:0]         row_ff;
   logic [2:0]         col_ff;
   logic               sat_ff;
   ladrc_pkg::rsp_type res_ff;
   ladrc_pkg::rsp_type rsp_ff;
   logic               rsp_valid_ff;

   ladrc_pkg::smul_ctrl_type mul_ctrl;
   logic signed [32:0] op_a;
   logic [31:0]        op_b;
   logic               mul_done;
   logic signed [65:0] mul_prod;

   logic               accept;
   logic               load_out;
   logic               last_op;
   logic               ctrl_row;
   logic [47:0]        mat_row;
   logic [15:0]        bu_coef;
   logic [15:0]        by_coef;

   logic signed [55:0] acc_sum;
   logic signed [55:0] obs_rnd;
   logic signed [65:0] prod_r16;
   logic signed [65:0] prod_r24;
   logic signed [51:0] v_wide;
   ladrc_pkg::clip32_type obs_clip;
   ladrc_pkg::clip32_type v_clip;
   ladrc_pkg::clip16_type drive_clip;

   function automatic logic [15:0] pick16(input logic [47:0] w, input logic [1:0] k);
      logic [15:0] r;
      unique case (k)
         2'd0:    r = w[15:0];
         2'd1:    r = w[31:16];
         default: r = w[47:32];
      endcase
      return r;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ladrc_pkg::ST_IDLE);
   assign load_out  = !rsp_valid_ff || rsp_ready;
   assign ctrl_row  = (row_ff == 2'd3);
   assign last_op   = ctrl_row && (col_ff == 3'd2);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         obs_row0_ff <= '0;
         obs_row1_ff <= '0;
         obs_row2_ff <= '0;
         bu_ff       <= '0;
         by_ff       <= '0;
         gain_p_ff   <= '0;
         gain_d_ff   <= '0;
         inv_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ladrc_pkg::CSR_OBS_ROW0:  obs_row0_ff <= csr_wdata;
            ladrc_pkg::CSR_OBS_ROW1:  obs_row1_ff <= csr_wdata;
            ladrc_pkg::CSR_OBS_ROW2:  obs_row2_ff <= csr_wdata;
            ladrc_pkg::CSR_DRIVE_IN:  bu_ff       <= csr_wdata;
            ladrc_pkg::CSR_MEAS_IN:   by_ff       <= csr_wdata;
            ladrc_pkg::CSR_GAIN_P:    gain_p_ff   <= csr_wdata[31:0];
            ladrc_pkg::CSR_GAIN_D:    gain_d_ff   <= csr_wdata[31:0];
            ladrc_pkg::CSR_INV_PLANT: inv_ff      <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Operand selection. Rows 0 to 2 are the observer rows, each summing the three matrix
   // terms, the drive term and the measurement term; row 3 holds the controller multiplies.
   always_comb begin
      unique case (row_ff)
         2'd0:    mat_row = obs_row0_ff;
         2'd1:    mat_row = obs_row1_ff;
         default: mat_row = obs_row2_ff;
      endcase
      bu_coef = pick16(bu_ff, row_ff);
      by_coef = pick16(by_ff, row_ff);
      op_a = '0;
      op_b = '0;
      if (ctrl_row) begin
         unique case (col_ff)
            3'd0: begin
               // Setpoint error against the new position estimate.
               op_a = {{9{r_ff[15]}}, r_ff, 8'h00} - {nx_ff[0][31], nx_ff[0]};
               op_b = gain_p_ff;
            end
            3'd1: begin
               op_a = {nx_ff[1][31], nx_ff[1]};
               op_b = gain_d_ff;
            end
            default: begin
               op_a = {v_ff[31], v_ff};
               op_b = inv_ff;
            end
         endcase
      end else begin
         unique case (col_ff)
            3'd0: begin
               op_a = {est_ff[0][31], est_ff[0]};
               op_b = {{16{mat_row[15]}}, mat_row[15:0]};
            end
            3'd1: begin
               op_a = {est_ff[1][31], est_ff[1]};
               op_b = {{16{mat_row[31]}}, mat_row[31:16]};
            end
            3'd2: begin
               op_a = {est_ff[2][31], est_ff[2]};
               op_b = {{16{mat_row[47]}}, mat_row[47:32]};
            end
            3'd3: begin
               // The drive and measurement are raised to the estimate scale first.
               op_a = {{9{u_ff[15]}}, u_ff, 8'h00};
               op_b = {{16{bu_coef[15]}}, bu_coef};
            end
            default: begin
               op_a = {{9{y_ff[15]}}, y_ff, 8'h00};
               op_b = {{16{by_coef[15]}}, by_coef};
            end
         endcase
      end
      mul_ctrl.start   = (state_ff == ladrc_pkg::ST_ISSUE);
      mul_ctrl.long_op = ctrl_row;
   end

   ladrc_smul u_smul (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mul_ctrl),
      .a_in    (op_a),
      .b_in    (op_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Rounding and saturation of finished products.
   always_comb begin
      acc_sum    = acc_ff + mul_prod[55:0];
      obs_rnd    = acc_sum + 56'sd8192;
      obs_clip   = ladrc_pkg::clip32({{24{obs_rnd[55]}}, obs_rnd[55:14]});
      prod_r16   = mul_prod + 66'sd32768;
      v_wide     = {{2{p_ff[49]}}, p_ff} - {{2{prod_r16[65]}}, prod_r16[65:16]}
                   - {{20{nx_ff[2][31]}}, nx_ff[2]};
      v_clip     = ladrc_pkg::clip32({{14{v_wide[51]}}, v_wide});
      prod_r24   = mul_prod + 66'sd8388608;
      drive_clip = ladrc_pkg::clip16({{24{prod_r24[65]}}, prod_r24[65:24]});
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ladrc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = req_data.action ? ladrc_pkg::ST_FIN : ladrc_pkg::ST_ISSUE;
            end
         end
         ladrc_pkg::ST_ISSUE: state_in = ladrc_pkg::ST_WAIT;
         ladrc_pkg::ST_WAIT: begin
            if (mul_done) begin
               state_in = last_op ? ladrc_pkg::ST_FIN : ladrc_pkg::ST_ISSUE;
            end
         end
         default: begin
            if (load_out) begin
               state_in = ladrc_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ladrc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ladrc_pkg::ST_FIN && load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Estimates are state and clear on reset and on an accepted clear item.
   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff[0] <= '0;
         est_ff[1] <= '0;
         est_ff[2] <= '0;
      end else if (accept && req_data.action) begin
         est_ff[0] <= '0;
         est_ff[1] <= '0;
         est_ff[2] <= '0;
      end else if (state_ff == ladrc_pkg::ST_WAIT && mul_done && last_op) begin
         // All rows used the old estimates, so the new ones commit together.
         est_ff[0] <= nx_ff[0];
         est_ff[1] <= nx_ff[1];
         est_ff[2] <= nx_ff[2];
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         u_ff   <= req_data.applied_drive;
         y_ff   <= req_data.measured;
         r_ff   <= req_data.setpoint;
         row_ff <= '0;
         col_ff <= '0;
         acc_ff <= '0;
         sat_ff <= 1'b0;
         if (req_data.action) begin
            res_ff <= '0;
         end
      end else if (state_ff == ladrc_pkg::ST_WAIT && mul_done) begin
         if (!ctrl_row) begin
            if (col_ff == 3'd4) begin
               unique case (row_ff)
                  2'd0:    nx_ff[0] <= obs_clip.value;
                  2'd1:    nx_ff[1] <= obs_clip.value;
                  default: nx_ff[2] <= obs_clip.value;
               endcase
               sat_ff <= sat_ff | obs_clip.hit;
               acc_ff <= '0;
               row_ff <= row_ff + 2'd1;
               col_ff <= '0;
            end else begin
               acc_ff <= acc_sum;
               col_ff <= col_ff + 3'd1;
            end
         end else begin
            unique case (col_ff)
               3'd0: begin
                  p_ff   <= prod_r16[65:16];
                  col_ff <= 3'd1;
               end
               3'd1: begin
                  v_ff   <= v_clip.value;
                  sat_ff <= sat_ff | v_clip.hit;
                  col_ff <= 3'd2;
               end
               default: begin
                  res_ff.drive           <= drive_clip.value;
                  res_ff.est_position    <= nx_ff[0];
                  res_ff.est_rate        <= nx_ff[1];
                  res_ff.est_disturbance <= nx_ff[2];
                  res_ff.saturated       <= sat_ff | drive_clip.hit;
               end
            endcase
         end
      end
      if (state_ff == ladrc_pkg::ST_FIN && load_out) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/ladrc_smul.sv -----
// Bit-serial signed multiplier: one multiplier bit per cycle into a shifting accumulator.
module ladrc_smul (
   input  logic                     clock,
   input  logic                     reset,
   input  ladrc_pkg::smul_ctrl_type ctrl,
   input  logic signed [32:0]       a_in,
   input  logic [31:0]              b_in,
   output logic                     done,
   output logic signed [65:0]       product
);

   logic signed [32:0] a_ff;
   logic [31:0]        b_ff;
   logic signed [33:0] hi_ff;
   logic [31:0]        lo_ff;
   logic [4:0]         cnt_ff;
   logic               busy_ff;
   logic               long_ff;
   logic               done_ff;

   logic               last;
   logic signed [33:0] addend;
   logic signed [33:0] sum;

   always_comb begin
      last = long_ff ? (cnt_ff == 5'd31) : (cnt_ff == 5'd15);
      if (!b_ff[0]) begin
         addend = '0;
      end else if (last) begin
         // The top bit of a two's complement multiplier carries negative weight.
         addend = -{a_ff[32], a_ff};
      end else begin
         addend = {a_ff[32], a_ff};
      end
      sum = hi_ff + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (ctrl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && last) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         hi_ff   <= '0;
         lo_ff   <= '0;
         cnt_ff  <= '0;
         long_ff <= ctrl.long_op;
      end else if (busy_ff) begin
         hi_ff  <= {sum[33], sum[33:1]};
         lo_ff  <= {sum[0], lo_ff[31:1]};
         b_ff   <= {1'b0, b_ff[31:1]};
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   assign done    = done_ff;
   assign product = long_ff ? {hi_ff, lo_ff} : {{16{hi_ff[33]}}, hi_ff, lo_ff[31:16]};

endmodule

// ----- rtl/ladrc_checker.sv -----
// Port-level checker of the ADRC observer and controller core, with its bind.
`include "linear_adrc_observer_controller_core_defines.svh"

module ladrc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input ladrc_pkg::rsp_type rsp_data
);

   `LADRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `LADRC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data))
   `LADRC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `LADRC_ASSERT_SAME(a_reset_quiet, $past(reset), !rsp_valid)

endmodule

bind linear_adrc_observer_controller_core ladrc_checker u_ladrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- bench/linear_adrc_observer_controller_core_tb.sv -----
// Self-checking testbench of the second-order linear ADRC observer and controller core.
module linear_adrc_observer_controller_core_tb;

   // Item actions as carried in the action field of an input item.
   localparam logic ACT_STEP  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // The limit is set from the length of a control step, the longest gaps and stalls
   // on both sides, and then taken several times over.
   localparam longint CYCLE_LIMIT = 64'd6_000_000;
   localparam int     DRAIN_CYCLES = 40;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   ladrc_pkg::req_type               req_data;
   logic                             rsp_valid;
   logic                             rsp_ready;
   ladrc_pkg::rsp_type               rsp_data;
   logic                             csr_we;
   logic [ladrc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ladrc_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Shadow copy of the block's registers and observer state.
   logic [47:0]        obs_row [3];
   logic [47:0]        drive_gains;
   logic [47:0]        meas_gains;
   logic signed [31:0] kp;
   logic signed [31:0] kd;
   logic signed [31:0] inv_b0;
   int                 est [3];

   ladrc_pkg::rsp_type expected_rsps [$];
   longint  cycle_count;
   int      mismatch_count;
   int      hold_request;
   bit      quiet_mode;

   linear_adrc_observer_controller_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor of the observer and controller arithmetic.
   // ---------------------------------------------------------------------------

   // Signed Q2.14 coefficient j of a packed 48-bit register.
   function automatic longint coef_of(input logic [47:0] w, input int j);
      logic signed [15:0] c;
      c = w[16*j +: 16];
      return longint'(c);
   endfunction

   // Round half towards plus infinity while dropping k fraction bits.
   function automatic longint round_down_bits(input longint v, input int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic longint clip_bits(input longint v, input int bits, inout bit hit);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // Advances the shadow observer by one item and returns the result it should give.
   function automatic ladrc_pkg::rsp_type predict_drive(input ladrc_pkg::req_type q);
      ladrc_pkg::rsp_type r;
      longint  acc;
      longint  nx [3];
      longint  err;
      longint  p_term;
      longint  d_term;
      longint  v;
      longint  u;
      longint  y;
      bit      hit;
      hit = 1'b0;
      r   = '0;
      if (q.action == ACT_CLEAR) begin
         for (int i = 0; i < 3; i++) est[i] = 0;
         return r;
      end
      u = longint'(q.applied_drive);
      y = longint'(q.measured);
      // All three rows see the estimates from before this step.
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) acc += coef_of(obs_row[i], j) * longint'(est[j]);
         acc += coef_of(drive_gains, i) * u * 256;
         acc += coef_of(meas_gains, i) * y * 256;
         nx[i] = clip_bits(round_down_bits(acc, 14), 32, hit);
      end
      for (int i = 0; i < 3; i++) est[i] = int'(nx[i]);
      err    = longint'(q.setpoint) * 256 - nx[0];
      p_term = round_down_bits(longint'(kp) * err, 16);
      d_term = round_down_bits(longint'(kd) * nx[1], 16);
      // The sum is clipped before the plant gain is applied; that clip counts too.
      v = clip_bits(p_term - d_term - nx[2], 32, hit);
      r.drive           = 16'(clip_bits(round_down_bits(v * longint'(inv_b0), 24), 16, hit));
      r.est_position    = est[0];
      r.est_rate        = est[1];
      r.est_disturbance = est[2];
      r.saturated       = hit;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: stalls on the receiver and the comparison of every item taken.
   // ---------------------------------------------------------------------------

   // Ready is driven with random stalls, mostly short and a few long. A hold request
   // from a test keeps it low for a counted stretch, and quiet mode keeps it high.
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (hold_request > 0) begin
         rsp_ready    <= 1'b0;
         hold_request <= hold_request - 1;
      end else if (quiet_mode) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Each result taken is compared field by field with the oldest expectation.
   always @(posedge clock) begin
      ladrc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result item: drive %0d est %0d %0d %0d sat %0b",
                        rsp_data.drive, rsp_data.est_position, rsp_data.est_rate,
                        rsp_data.est_disturbance, rsp_data.saturated);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"Result mismatch (expected/actual): drive %0d/%0d ",
                            "pos %0d/%0d rate %0d/%0d dist %0d/%0d sat %0b/%0b"},
                           want.drive, rsp_data.drive,
                           want.est_position, rsp_data.est_position,
                           want.est_rate, rsp_data.est_rate,
                           want.est_disturbance, rsp_data.est_disturbance,
                           want.saturated, rsp_data.saturated);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sender side and register access.
   // ---------------------------------------------------------------------------

   // Offers one item and holds it until it is taken; the expectation is formed at the
   // edge of acceptance, so the shadow state advances in the same order as the block.
   task automatic send_item(input ladrc_pkg::req_type q);
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(predict_drive(q));
   endtask

   // A gap after an item, short mostly and now and then long; none in quiet mode.
   task automatic sender_gap();
      int gap;
      gap = quiet_mode ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(20, 100)
                                                          : $urandom_range(0, 3));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every expected result is back and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ladrc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [47:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         ladrc_pkg::CSR_OBS_ROW0:  obs_row[0]  = value;
         ladrc_pkg::CSR_OBS_ROW1:  obs_row[1]  = value;
         ladrc_pkg::CSR_OBS_ROW2:  obs_row[2]  = value;
         ladrc_pkg::CSR_DRIVE_IN:  drive_gains = value;
         ladrc_pkg::CSR_MEAS_IN:   meas_gains  = value;
         ladrc_pkg::CSR_GAIN_P:    kp          = value[31:0];
         ladrc_pkg::CSR_GAIN_D:    kd          = value[31:0];
         ladrc_pkg::CSR_INV_PLANT: inv_b0      = value[31:0];
         default: ;
      endcase
   endtask

   // Loads a full register set; the block must already be idle.
   task automatic load_all(input logic [47:0] a0, input logic [47:0] a1, input logic [47:0] a2,
                           input logic [47:0] bu, input logic [47:0] by,
                           input logic [31:0] p, input logic [31:0] d, input logic [31:0] ib);
      write_reg(ladrc_pkg::CSR_OBS_ROW0, a0);
      write_reg(ladrc_pkg::CSR_OBS_ROW1, a1);
      write_reg(ladrc_pkg::CSR_OBS_ROW2, a2);
      write_reg(ladrc_pkg::CSR_DRIVE_IN, bu);
      write_reg(ladrc_pkg::CSR_MEAS_IN, by);
      write_reg(ladrc_pkg::CSR_GAIN_P, {16'h0, p});
      write_reg(ladrc_pkg::CSR_GAIN_D, {16'h0, d});
      write_reg(ladrc_pkg::CSR_INV_PLANT, {16'h0, ib});
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] tame_coef(input int span);
      return 16'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic logic [47:0] tame_row(input int span);
      return {tame_coef(span), tame_coef(span), tame_coef(span)};
   endfunction

   function automatic logic [47:0] wide_word();
      return {16'($urandom), $urandom};
   endfunction

   // A well-behaved observer (near-identity matrix, small input gains) keeps the
   // estimates in range for long sequences; the wild form uses any bits at all.
   task automatic load_random(input bit wild);
      if (wild)
         load_all(wide_word(), wide_word(), wide_word(), wide_word(), wide_word(),
                  $urandom, $urandom, $urandom);
      else
         load_all({tame_coef(400), tame_coef(1600), 16'd15000 + tame_coef(900)},
                  {tame_coef(1600), 16'd15000 + tame_coef(900), tame_coef(400)},
                  {16'd15000 + tame_coef(900), tame_coef(400), tame_coef(400)},
                  tame_row(2000), tame_row(2000),
                  32'($urandom_range(0, 1 << 22) - (1 << 21)),
                  32'($urandom_range(0, 1 << 22) - (1 << 21)),
                  32'($urandom_range(0, 1 << 20) - (1 << 19)));
   endtask

   // A control step with random content, with a clear now and then.
   function automatic ladrc_pkg::req_type random_item();
      ladrc_pkg::req_type q;
      q.action        = ($urandom_range(0, 24) == 0) ? ACT_CLEAR : ACT_STEP;
      q.applied_drive = 16'($urandom);
      q.measured      = 16'($urandom);
      q.setpoint      = 16'($urandom);
      return q;
   endfunction

   function automatic ladrc_pkg::req_type make_item(input logic act, input logic [15:0] u,
                                                    input logic [15:0] y,
                                                    input logic [15:0] r);
      ladrc_pkg::req_type q;
      q.action        = act;
      q.applied_drive = u;
      q.measured      = y;
      q.setpoint      = r;
      return q;
   endfunction

   // ---------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------

   // With all registers at their reset value every step must give zeros.
   task automatic test_reset_values();
      send_item(make_item(ACT_STEP, 16'h7FFF, 16'h8000, 16'h7FFF));
      send_item(make_item(ACT_STEP, 16'h8000, 16'h7FFF, 16'h8000));
      send_item(make_item(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      wait_idle();
   endtask

   // Full-scale coefficients and inputs, both signs: every clip and the clip of the
   // intermediate sum get exercised, and a clear must zero everything afterwards.
   task automatic test_extremes();
      load_all({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(make_item(ACT_STEP, 16'h7FFF, 16'h7FFF, 16'h8000));
      send_item(make_item(ACT_STEP, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_item(make_item(ACT_STEP, 16'h8000, 16'h8000, 16'h8000));
      send_item(make_item(ACT_CLEAR, 16'h7FFF, 16'h8000, 16'h7FFF));
      send_item(make_item(ACT_STEP, 16'h0000, 16'h0000, 16'h0000));
      wait_idle();
      load_all({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(make_item(ACT_STEP, 16'h8000, 16'h7FFF, 16'h7FFF));
      send_item(make_item(ACT_STEP, 16'h8000, 16'h8000, 16'h8000));
      send_item(make_item(ACT_STEP, 16'h7FFF, 16'h7FFF, 16'h8000));
      send_item(make_item(ACT_STEP, 16'hFFFF, 16'h0001, 16'h0000));
      send_item(make_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000));
      wait_idle();
      // Unit proportional gain, inverse plant gain of one half: drive is half the error, so rounding at half is seen.
      load_all(48'h0, 48'h0, 48'h0, 48'h0, {32'h0, 16'h0001},
               32'h0001_0000, 32'h0000_0000, 32'h0000_8000);
      send_item(make_item(ACT_STEP, 16'h0000, 16'h0001, 16'h0001));
      send_item(make_item(ACT_STEP, 16'h0000, 16'hFFFF, 16'hFFFF));
      send_item(make_item(ACT_STEP, 16'h1234, 16'h8000, 16'h7FFF));
      wait_idle();
   endtask

   // A run of random items under one register setting.
   task automatic test_random_run(input int count, input bit wild);
      load_random(wild);
      for (int n = 0; n < count; n++) begin
         send_item(random_item());
         sender_gap();
      end
      wait_idle();
   endtask

   // The receiver holds off for a long counted stretch while items keep coming, so
   // the output register and the engine fill up and the input stalls.
   task automatic test_receiver_hold();
      load_random(1'b0);
      hold_request = 3000;
      for (int n = 0; n < 8; n++) send_item(random_item());
      wait_idle();
   endtask

   // The sender pauses until every result is back, then resumes, a few times over.
   task automatic test_sender_pause();
      load_random(1'b0);
      for (int k = 0; k < 5; k++) begin
         for (int n = 0; n < 4; n++) begin
            send_item(random_item());
            sender_gap();
         end
         wait_idle();
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      rsp_ready      = 1'b0;
      cycle_count    = 0;
      mismatch_count = 0;
      hold_request   = 0;
      quiet_mode     = 1'b0;
      obs_row[0]     = '0;
      obs_row[1]     = '0;
      obs_row[2]     = '0;
      drive_gains    = '0;
      meas_gains     = '0;
      kp             = '0;
      kd             = '0;
      inv_b0         = '0;
      for (int i = 0; i < 3; i++) est[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_extremes();
      test_receiver_hold();
      test_sender_pause();
      test_random_run(350, 1'b0);
      test_random_run(250, 1'b1);
      quiet_mode = 1'b1;
      test_random_run(300, 1'b0);
      quiet_mode = 1'b0;
      test_random_run(350, 1'b0);
      test_random_run(250, 1'b1);
      test_random_run(350, 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
